[rtl/core/psu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants and types for the scanline unfilter: line store sizing,
// register indexes, filter type codes and the stage control struct.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int MAX_ROW_BYTES   = 16384;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int BIDX_W = $clog2(MAX_PIXEL_BYTES);
    localparam int BPP_W  = 4;
    localparam int ROW_W  = 15;
    localparam int CFG_W  = 15;

    typedef enum logic [0:0] {
        CFG_BPP       = 1'b0,
        CFG_ROW_BYTES = 1'b1
    } t_cfg_index;

    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    typedef struct packed {
        logic [7:0]        filter;
        logic              first_row;
        logic              left_ok;
        logic              row_end;
        logic [BIDX_W-1:0] bpp_idx;
    } t_s1_ctrl;

endpackage

[rtl/core/psu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/png_scanline_unfilter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) on a
// byte stream of type bytes and filtered data bytes.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, type byte or data byte, with no
// bubbles while the output is not held. A data byte passes through the
// registered read of the previous row from the line store, then the
// predictor and the output register. The line store needs no clearing
// after reset; it is filled by the first row. Configuration writes take
// effect for the next byte.
module png_scanline_unfilter
    import psu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_byte_in,
    input  logic             i_image_start,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_byte_out,
    output logic             o_row_end,
    output logic             o_bad_filter
);

    // configuration
    logic [BPP_W-1:0] r_bpp;
    logic [ROW_W-1:0] r_row_bytes;

    // row control
    logic             r_awaiting;
    logic             r_first_row;
    logic [COL_W-1:0] r_col;
    logic [7:0]       r_filter;

    // stage 1
    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic [COL_W-1:0] r_s1_col;
    t_s1_ctrl         r_s1;

    // output register
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;
    logic             r_out_bad;

    // neighbor history, newest first
    logic [7:0] r_left       [0:MAX_PIXEL_BYTES-1];
    logic [7:0] r_above_left [0:MAX_PIXEL_BYTES-1];

    logic             in_accept;
    logic             s1_adv;
    logic             s0_awaiting;
    logic             s0_data;
    logic [BPP_W-1:0] bpp_eff;
    logic [ROW_W-1:0] rb_eff;
    logic [COL_W:0]   col_inc;
    logic             s0_end;
    logic             s0_left_ok;
    t_s1_ctrl         n_s1;

    logic [7:0] above_rd;
    logic [7:0] a_val;
    logic [7:0] b_val;
    logic [7:0] c_val;
    logic [7:0] pred;
    logic [7:0] recon;
    logic       bad;
    logic [8:0] sum_ab;
    logic [9:0] ab_ext;
    logic [9:0] cc_ext;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [9:0] pc;

    // handshakes
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // stage 0: type byte detection and column bookkeeping
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = r_bpp;
        end
        if (r_row_bytes == '0) begin
            rb_eff = ROW_W'(1);
        end else if (r_row_bytes > ROW_W'(MAX_ROW_BYTES)) begin
            rb_eff = ROW_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = r_row_bytes;
        end
        s0_awaiting     = r_awaiting || i_image_start;
        s0_data         = in_accept && !s0_awaiting;
        col_inc         = {1'b0, r_col} + (COL_W+1)'(1);
        s0_end          = ROW_W'(col_inc) >= rb_eff;
        s0_left_ok      = ROW_W'(r_col) >= ROW_W'(bpp_eff);
        n_s1.filter     = r_filter;
        n_s1.first_row  = r_first_row;
        n_s1.left_ok    = s0_left_ok;
        n_s1.row_end    = s0_end;
        n_s1.bpp_idx    = BIDX_W'(bpp_eff - BPP_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(4);
            r_row_bytes <= ROW_W'(4);
            r_awaiting  <= 1'b1;
            r_first_row <= 1'b1;
            r_col       <= '0;
            r_filter    <= FILT_NONE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                    CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[ROW_W-1:0];
                    default:       r_bpp       <= r_bpp;
                endcase
            end
            if (in_accept) begin
                if (s0_awaiting) begin
                    r_filter    <= i_byte_in;
                    r_awaiting  <= 1'b0;
                    r_col       <= '0;
                    r_first_row <= r_first_row || i_image_start;
                end else if (s0_end) begin
                    r_awaiting  <= 1'b1;
                    r_first_row <= 1'b0;
                    r_col       <= '0;
                end else begin
                    r_col       <= col_inc[COL_W-1:0];
                end
            end
            if (s0_data) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_data) begin
            r_s1_byte <= i_byte_in;
            r_s1_col  <= r_col;
            r_s1      <= n_s1;
        end
        if (s1_adv) begin
            r_out_byte <= recon;
            r_out_end  <= r_s1.row_end;
            r_out_bad  <= bad;
            r_left[0]       <= recon;
            r_above_left[0] <= b_val;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]       <= r_left[i-1];
                r_above_left[i] <= r_above_left[i-1];
            end
        end
    end

    // line store holding the previous reconstructed row
    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_above_row (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (recon),
        .i_re    (s0_data),
        .i_raddr (r_col),
        .o_rdata (above_rd)
    );

    // stage 1: predictor and reconstruction
    always_comb begin
        b_val  = r_s1.first_row ? 8'd0 : above_rd;
        a_val  = r_s1.left_ok ? r_left[r_s1.bpp_idx] : 8'd0;
        c_val  = (r_s1.left_ok && !r_s1.first_row) ? r_above_left[r_s1.bpp_idx] : 8'd0;
        sum_ab = {1'b0, a_val} + {1'b0, b_val};
        ab_ext = {1'b0, sum_ab};
        cc_ext = {1'b0, c_val, 1'b0};
        pa     = (b_val >= c_val) ? (b_val - c_val) : (c_val - b_val);
        pb     = (a_val >= c_val) ? (a_val - c_val) : (c_val - a_val);
        pc     = (ab_ext >= cc_ext) ? (ab_ext - cc_ext) : (cc_ext - ab_ext);
        bad    = 1'b0;
        case (r_s1.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = a_val;
            FILT_UP:    pred = b_val;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: begin
                if ({2'b0, pa} <= {2'b0, pb} && {2'b0, pa} <= pc) begin
                    pred = a_val;
                end else if ({2'b0, pb} <= pc) begin
                    pred = b_val;
                end else begin
                    pred = c_val;
                end
            end
            default: begin
                pred = 8'd0;
                bad  = 1'b1;
            end
        endcase
        recon = r_s1_byte + pred;
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_out_byte;
    assign o_row_end    = r_out_end;
    assign o_bad_filter = r_out_bad;

    // stall only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // line store write and read never meet on the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s0_data) |-> (r_s1_col != r_col))
        else $error("line store read and write collide");

    // last data byte of a row rearms type byte detection
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_data && s0_end) |=> (r_awaiting && r_col == '0 && !r_first_row))
        else $error("row end did not rearm type byte");

endmodule
